// ===== src/dhftc_pkg.sv =====
// ----------------------------------------------------------------------------
// dhftc_pkg
// Shared types and constants of the dryer heater and fan timer controller.
// ----------------------------------------------------------------------------
package dhftc_pkg;

    localparam int BUTTON_COUNT = 4;

    localparam int DEBOUNCE_W = 8;
    localparam int TICK_W     = 17;
    localparam int MINUTES_W  = 11;
    localparam int CELSIUS_W  = 7;
    localparam int SAMPLE_W   = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    // reset values of the settings and state
    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST     = 8'd30;
    localparam logic [TICK_W-1:0]     MINUTE_RST       = 17'd60000;
    localparam logic [TICK_W-1:0]     RUNON_RST        = 17'd60000;
    localparam logic [MINUTES_W-1:0]  TIME_LIMIT_RST   = 11'd1440;
    localparam logic [CELSIUS_W-1:0]  TEMP_FLOOR_RST   = 7'd20;
    localparam logic [CELSIUS_W-1:0]  TEMP_CEILING_RST = 7'd80;
    localparam logic [MINUTES_W-1:0]  TARGET_MIN_RST   = 11'd90;
    localparam logic [CELSIUS_W-1:0]  TARGET_TEMP_RST  = 7'd20;

    localparam logic [TICK_W-1:0]     TICK_MAX       = '1;
    localparam logic [DEBOUNCE_W-1:0] SINCE_MAX      = '1;
    localparam logic [MINUTES_W:0]    HOUR_STEP      = 12'd60;

    // setting register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE     = 3'd0,
        CFG_MINUTE       = 3'd1,
        CFG_RUNON        = 3'd2,
        CFG_TIME_LIMIT   = 3'd3,
        CFG_TEMP_FLOOR   = 3'd4,
        CFG_TEMP_CEILING = 3'd5
    } cfg_idx_t;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_TIME = 2'd1,
        MODE_TEMP = 2'd2,
        MODE_WORK = 2'd3
    } mode_t;

    typedef struct packed {
        logic [DEBOUNCE_W-1:0] debounce_ms;
        logic [TICK_W-1:0]     minute_ms;
        logic [TICK_W-1:0]     fan_runon_ms;
        logic [MINUTES_W-1:0]  time_limit;
        logic [CELSIUS_W-1:0]  temp_floor;
        logic [CELSIUS_W-1:0]  temp_ceiling;
    } cfg_t;

    typedef struct packed {
        logic [BUTTON_COUNT-1:0]    raw_buttons;
        logic                       temp_valid;
        logic signed [SAMPLE_W-1:0] temp_sample;
    } in_item_t;

    typedef struct packed {
        logic                  heater_on;
        logic                  fan_on;
        logic [1:0]            mode;
        logic [MINUTES_W-1:0]  set_minutes;
        logic [CELSIUS_W-1:0]  set_celsius;
        logic [MINUTES_W-1:0]  left_minutes;
        logic [CELSIUS_W-1:0]  held_temp;
        logic                  save_minutes;
        logic                  save_celsius;
    } out_item_t;

endpackage

// ===== src/dhftc_if.sv =====
// ----------------------------------------------------------------------------
// dhftc channel interfaces
// Valid/ready channels for tick beats, result beats and setting writes.
// ----------------------------------------------------------------------------
interface dhftc_in_if;
    logic                 valid;
    logic                 ready;
    dhftc_pkg::in_item_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface dhftc_out_if;
    logic                 valid;
    logic                 ready;
    dhftc_pkg::out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface dhftc_cfg_if;
    logic                                   valid;
    logic                                   ready;
    logic [dhftc_pkg::CFG_IDX_W-1:0]        index;
    logic [dhftc_pkg::CFG_DATA_W-1:0]       data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/dryer_heater_fan_timer_controller.sv =====
// ----------------------------------------------------------------------------
// dryer_heater_fan_timer_controller
// Debounced four-button dryer controller with thermostat and minute timer.
//
//   channel   direction  carries
//   in_ch     sink       one 1 ms tick: raw buttons, temperature sample
//   out_ch    source     one result per tick: drives, mode, settings, saves
//   cfg       sink       setting write: index, data (always ready)
//
// A tick beat enters an input register, is worked combinationally by the
// debouncers and the mode logic, and lands in the result register when that
// register is free or being emptied. One tick is taken every cycle while
// results drain; a stalled result holds the input register, and a new tick
// is still taken into it when that register is free. Reset is asynchronous.
// ----------------------------------------------------------------------------
module dryer_heater_fan_timer_controller (
    input  logic          clk,
    input  logic          rst_n,
    dhftc_in_if.sink      in_ch,
    dhftc_out_if.source   out_ch,
    dhftc_cfg_if.sink     cfg
);

    dhftc_pkg::cfg_t                    settings;
    dhftc_pkg::in_item_t                in_data_reg;
    logic                               in_valid_reg;
    dhftc_pkg::out_item_t               out_data_reg;
    logic                               out_valid_reg;
    dhftc_pkg::out_item_t               result;
    logic [dhftc_pkg::BUTTON_COUNT-1:0] press;
    logic                               advance;

    // stage moves when the result register is free or being emptied
    assign advance      = in_valid_reg & (~out_valid_reg | out_ch.ready);
    assign in_ch.ready  = ~in_valid_reg | advance;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_data_reg;

    dhftc_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .settings (settings)
    );

    dhftc_debounce u_debounce (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (advance),
        .raw         (in_data_reg.raw_buttons),
        .debounce_ms (settings.debounce_ms),
        .press       (press)
    );

    dhftc_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (advance),
        .settings    (settings),
        .press       (press),
        .temp_valid  (in_data_reg.temp_valid),
        .temp_sample (in_data_reg.temp_sample),
        .result      (result)
    );

    // input register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ch.ready)
            in_valid_reg <= in_ch.valid;
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
            in_data_reg <= in_ch.data;
    end

    // result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (advance)
            out_data_reg <= result;
    end

endmodule

// ===== src/dhftc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// dhftc_cfg_regs
// Setting registers, written one at a time through the setting channel.
// ----------------------------------------------------------------------------
module dhftc_cfg_regs (
    input  logic               clk,
    input  logic               rst_n,
    dhftc_cfg_if.sink          cfg,
    output dhftc_pkg::cfg_t    settings
);

    dhftc_pkg::cfg_t cfg_reg;

    // always ready for a write beat
    assign cfg.ready = 1'b1;
    assign settings  = cfg_reg;

    // register write, unknown indexes dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ms  <= dhftc_pkg::DEBOUNCE_RST;
            cfg_reg.minute_ms    <= dhftc_pkg::MINUTE_RST;
            cfg_reg.fan_runon_ms <= dhftc_pkg::RUNON_RST;
            cfg_reg.time_limit   <= dhftc_pkg::TIME_LIMIT_RST;
            cfg_reg.temp_floor   <= dhftc_pkg::TEMP_FLOOR_RST;
            cfg_reg.temp_ceiling <= dhftc_pkg::TEMP_CEILING_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                dhftc_pkg::CFG_DEBOUNCE:
                    cfg_reg.debounce_ms  <= cfg.data[dhftc_pkg::DEBOUNCE_W-1:0];
                dhftc_pkg::CFG_MINUTE:
                    cfg_reg.minute_ms    <= cfg.data[dhftc_pkg::TICK_W-1:0];
                dhftc_pkg::CFG_RUNON:
                    cfg_reg.fan_runon_ms <= cfg.data[dhftc_pkg::TICK_W-1:0];
                dhftc_pkg::CFG_TIME_LIMIT:
                    cfg_reg.time_limit   <= cfg.data[dhftc_pkg::MINUTES_W-1:0];
                dhftc_pkg::CFG_TEMP_FLOOR:
                    cfg_reg.temp_floor   <= cfg.data[dhftc_pkg::CELSIUS_W-1:0];
                dhftc_pkg::CFG_TEMP_CEILING:
                    cfg_reg.temp_ceiling <= cfg.data[dhftc_pkg::CELSIUS_W-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

endmodule

// ===== src/dhftc_debounce.sv =====
// ----------------------------------------------------------------------------
// dhftc_debounce
// Per-button debouncers; a falling stable level gives a one-tick press.
// ----------------------------------------------------------------------------
module dhftc_debounce (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   en,
    input  logic [dhftc_pkg::BUTTON_COUNT-1:0]     raw,
    input  logic [dhftc_pkg::DEBOUNCE_W-1:0]       debounce_ms,
    output logic [dhftc_pkg::BUTTON_COUNT-1:0]     press
);

    logic [dhftc_pkg::BUTTON_COUNT-1:0] last_reg, last_next;
    logic [dhftc_pkg::BUTTON_COUNT-1:0] stable_reg, stable_next;
    logic [dhftc_pkg::DEBOUNCE_W-1:0]   since_reg  [dhftc_pkg::BUTTON_COUNT];
    logic [dhftc_pkg::DEBOUNCE_W-1:0]   since_next [dhftc_pkg::BUTTON_COUNT];

    // hold counter and stable level per button
    always_comb
    begin
        for (int i = 0; i < dhftc_pkg::BUTTON_COUNT; i++)
        begin
            last_next[i]   = raw[i];
            stable_next[i] = stable_reg[i];
            press[i]       = 1'b0;
            if (raw[i] != last_reg[i])
                since_next[i] = '0;
            else if (since_reg[i] != dhftc_pkg::SINCE_MAX)
                since_next[i] = since_reg[i] + 1'b1;
            else
                since_next[i] = since_reg[i];
            if (since_next[i] >= debounce_ms && raw[i] != stable_reg[i])
            begin
                stable_next[i] = raw[i];
                press[i]       = ~raw[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg   <= '1;
            stable_reg <= '1;
            for (int i = 0; i < dhftc_pkg::BUTTON_COUNT; i++)
                since_reg[i] <= '0;
        end
        else if (en)
        begin
            last_reg   <= last_next;
            stable_reg <= stable_next;
            for (int i = 0; i < dhftc_pkg::BUTTON_COUNT; i++)
                since_reg[i] <= since_next[i];
        end
    end

endmodule

// ===== src/dhftc_core.sv =====
// ----------------------------------------------------------------------------
// dhftc_core
// Mode machine, setting edits, thermostat, minute countdown and fan run-on.
// ----------------------------------------------------------------------------
module dhftc_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  dhftc_pkg::cfg_t                     settings,
    input  logic [dhftc_pkg::BUTTON_COUNT-1:0]  press,
    input  logic                                temp_valid,
    input  logic signed [dhftc_pkg::SAMPLE_W-1:0] temp_sample,
    output dhftc_pkg::out_item_t                result
);

    localparam int MW = dhftc_pkg::MINUTES_W;
    localparam int CW = dhftc_pkg::CELSIUS_W;
    localparam int TW = dhftc_pkg::TICK_W;

    dhftc_pkg::mode_t mode_reg, mode_next;
    logic [MW-1:0]    target_min_reg, target_min_next;
    logic [CW-1:0]    target_temp_reg, target_temp_next;
    logic [MW-1:0]    remain_reg, remain_next;
    logic [CW-1:0]    hold_reg, hold_next;
    logic [TW-1:0]    minute_reg, minute_next;
    logic [TW-1:0]    runon_reg, runon_next;
    logic             heater_reg, heater_next;
    logic             fan_reg, fan_next;
    logic             prev_heater_reg, prev_heater_next;

    logic             b1, b2, b3, b4, stop_press;
    logic [MW:0]      t1, t2, t3;
    logic [CW:0]      c1, c2;
    logic [TW:0]      minute_inc;
    logic             minute_done;
    logic [MW-1:0]    remain_dec;
    logic             heat_w, fan_w;
    logic [TW-1:0]    runon_w;

    assign b1         = press[0];
    assign b2         = press[1];
    assign b3         = press[2];
    assign b4         = press[3];
    assign stop_press = b3 | b4;

    // clamped sample hold
    always_comb
    begin
        if (temp_valid)
            hold_next = temp_sample[dhftc_pkg::SAMPLE_W-1] ? '0 : temp_sample[CW-1:0];
        else
            hold_next = hold_reg;
    end

    // time set chain: +1, -1, +60
    always_comb
    begin
        t1 = {1'b0, target_min_reg};
        if (b1)
            t1 = (t1 + 1'b1 > {1'b0, settings.time_limit}) ?
                 {1'b0, settings.time_limit} : t1 + 1'b1;
        t2 = t1;
        if (b2)
            t2 = (t1 == '0) ? '0 : t1 - 1'b1;
        t3 = t2;
        if (b3)
        begin
            t3 = t2 + dhftc_pkg::HOUR_STEP;
            if (t3 > {1'b0, settings.time_limit})
                t3 = t3 - {1'b0, settings.time_limit};
            if (t3 > {1'b0, settings.time_limit})
                t3 = {1'b0, settings.time_limit};
        end
    end

    // temp set chain: +1 capped at ceiling, then -1 raised to floor
    always_comb
    begin
        c1 = {1'b0, target_temp_reg};
        if (b1)
            c1 = (c1 + 1'b1 > {1'b0, settings.temp_ceiling}) ?
                 {1'b0, settings.temp_ceiling} : c1 + 1'b1;
        c2 = c1;
        if (b2)
            c2 = (c1 == '0 || c1 - 1'b1 < {1'b0, settings.temp_floor}) ?
                 {1'b0, settings.temp_floor} : c1 - 1'b1;
    end

    // work tick: thermostat, minute count, run-on
    always_comb
    begin
        heat_w      = (hold_next < target_temp_reg);
        fan_w       = heat_w | fan_reg;
        minute_inc  = {1'b0, minute_reg} + 1'b1;
        minute_done = (minute_inc >= {1'b0, settings.minute_ms}) ||
                      (minute_inc > {1'b0, dhftc_pkg::TICK_MAX});
        remain_dec  = (remain_reg != '0) ? remain_reg - 1'b1 : remain_reg;
        if (!heat_w && prev_heater_reg)
            runon_w = '0;
        else if (runon_reg != dhftc_pkg::TICK_MAX)
            runon_w = runon_reg + 1'b1;
        else
            runon_w = runon_reg;
        if (runon_w >= settings.fan_runon_ms && !heat_w)
            fan_w = 1'b0;
    end

    // next mode
    always_comb
    begin
        mode_next = mode_reg;
        case (mode_reg)
            dhftc_pkg::MODE_IDLE:
            begin
                if (b1)
                    mode_next = dhftc_pkg::MODE_TIME;
                if (b2)
                    mode_next = dhftc_pkg::MODE_TEMP;
                if (stop_press)
                    mode_next = dhftc_pkg::MODE_WORK;
            end
            dhftc_pkg::MODE_TIME:
                if (b4)
                    mode_next = dhftc_pkg::MODE_IDLE;
            dhftc_pkg::MODE_TEMP:
                if (stop_press)
                    mode_next = dhftc_pkg::MODE_IDLE;
            dhftc_pkg::MODE_WORK:
            begin
                if (stop_press)
                    mode_next = dhftc_pkg::MODE_IDLE;
                else if (minute_done && remain_dec == '0)
                    mode_next = dhftc_pkg::MODE_IDLE;
                else if (!minute_done && remain_reg == '0)
                    mode_next = dhftc_pkg::MODE_IDLE;
            end
            default:
                mode_next = dhftc_pkg::MODE_IDLE;
        endcase
    end

    // datapath and result per mode
    always_comb
    begin
        target_min_next  = target_min_reg;
        target_temp_next = target_temp_reg;
        remain_next      = remain_reg;
        minute_next      = minute_reg;
        runon_next       = runon_reg;
        heater_next      = heater_reg;
        fan_next         = fan_reg;
        prev_heater_next = prev_heater_reg;
        result           = '0;
        case (mode_reg)
            dhftc_pkg::MODE_IDLE:
            begin
                heater_next = 1'b0;
                fan_next    = 1'b0;
                if (stop_press)
                begin
                    remain_next = target_min_reg;
                    minute_next = '0;
                    runon_next  = '0;
                end
            end
            dhftc_pkg::MODE_TIME:
            begin
                target_min_next     = t3[MW-1:0];
                result.save_minutes = b4;
            end
            dhftc_pkg::MODE_TEMP:
            begin
                target_temp_next    = c2[CW-1:0];
                result.save_celsius = stop_press;
            end
            dhftc_pkg::MODE_WORK:
            begin
                heater_next = heat_w;
                fan_next    = fan_w;
                minute_next = minute_done ? '0 : minute_inc[TW-1:0];
                remain_next = minute_done ? remain_dec : remain_reg;
                runon_next  = runon_w;
                if (remain_next == '0 || stop_press)
                begin
                    heater_next = 1'b0;
                    fan_next    = 1'b0;
                end
                if (stop_press)
                    remain_next = '0;
                prev_heater_next = heater_next;
            end
            default:
            begin
                heater_next = 1'b0;
                fan_next    = 1'b0;
            end
        endcase
        result.heater_on    = heater_next;
        result.fan_on       = fan_next;
        result.mode         = mode_next;
        result.set_minutes  = target_min_next;
        result.set_celsius  = target_temp_next;
        result.left_minutes = remain_next;
        result.held_temp    = hold_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= dhftc_pkg::MODE_IDLE;
            target_min_reg  <= dhftc_pkg::TARGET_MIN_RST;
            target_temp_reg <= dhftc_pkg::TARGET_TEMP_RST;
            remain_reg      <= '0;
            hold_reg        <= '0;
            minute_reg      <= '0;
            runon_reg       <= '0;
            heater_reg      <= 1'b0;
            fan_reg         <= 1'b0;
            prev_heater_reg <= 1'b0;
        end
        else if (en)
        begin
            mode_reg        <= mode_next;
            target_min_reg  <= target_min_next;
            target_temp_reg <= target_temp_next;
            remain_reg      <= remain_next;
            hold_reg        <= hold_next;
            minute_reg      <= minute_next;
            runon_reg       <= runon_next;
            heater_reg      <= heater_next;
            fan_reg         <= fan_next;
            prev_heater_reg <= prev_heater_next;
        end
    end

endmodule
